FILE: rtl/huffman_tree_walk_decoder_defines.svh
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH

// Check a property on every rising edge outside reset
`define HTWD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define HTWD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/htwd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Payload types, node entry layout, item kinds and controller links.
// ----------------------------------------------------------------------------
package htwd_pkg;

  localparam int HTWD_NODE_COUNT = 512;
  localparam int IDX_W           = 9;
  localparam int SYM_W           = 8;
  localparam int BITS_W          = 48;
  localparam int BYTE_BITS       = 8;
  localparam int BIT_SEL_W       = $clog2(BYTE_BITS);
  localparam int BIT_CNT_W       = $clog2(BYTE_BITS + 1);

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] node_index;
    logic             left_present;
    logic [IDX_W-1:0] left_child;
    logic             right_present;
    logic [IDX_W-1:0] right_child;
    logic [SYM_W-1:0] leaf_symbol;
    logic [SYM_W-1:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic              has_symbol;
    logic [SYM_W-1:0]  symbol;
    logic [BITS_W-1:0] bits_consumed;
    logic              failed;
    logic              last;
  } out_item_t;

  // One node table entry
  typedef struct packed {
    logic             left_present;
    logic [IDX_W-1:0] left_child;
    logic             right_present;
    logic [IDX_W-1:0] right_child;
    logic [SYM_W-1:0] symbol;
  } node_t;

  // Controller to datapath
  typedef struct packed {
    logic                 accept;
    logic                 step;
    logic                 finish;
    logic                 emit_sym;
    logic                 emit_stat;
    logic [BIT_SEL_W-1:0] bit_sel;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                 walk_go;
    logic [BIT_CNT_W-1:0] nbits;
    logic                 need_emit;
    logic                 bit_fail;
    logic                 out_free;
  } dp_stat_t;

endpackage

FILE: rtl/htwd_ctrl.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder: controller
// Sequences item acceptance, the per-bit walk and result emission.
// ----------------------------------------------------------------------------
module htwd_ctrl
  import htwd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [BIT_CNT_W-1:0] nbits_q, nbits_d;
  logic                 stall;

  assign in_ready_o = (state_q == S_IDLE);
  assign stall      = stat_i.need_emit && !stat_i.out_free;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nbits_d = nbits_q;
    cmd_o   = '0;
    cmd_o.bit_sel = cnt_q[BIT_SEL_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.walk_go) begin
            state_d = S_WALK;
            cnt_d   = '0;
            nbits_d = stat_i.nbits;
          end else begin
            state_d = S_STAT;
          end
        end
      end
      S_WALK: begin
        // hold everything while a leaf symbol waits for the output register
        if (!stall) begin
          cmd_o.emit_sym = stat_i.need_emit;
          if (cnt_q < nbits_q) begin
            cmd_o.step = 1'b1;
            if (stat_i.bit_fail) begin
              state_d = S_STAT;
            end else begin
              cnt_d = cnt_q + BIT_CNT_W'(1);
            end
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_stat = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      nbits_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nbits_q <= nbits_d;
    end
  end

endmodule

FILE: rtl/htwd_datapath.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder: datapath
// Node memory, walk registers, bit counters and the output register.
// ----------------------------------------------------------------------------
module htwd_datapath
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = HTWD_NODE_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  in_item_t          in_data_i,
  input  logic              cfg_we_i,
  input  logic [BITS_W-1:0] cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  node_t             mem [NODE_COUNT];
  node_t             rdata_q;
  node_t             cur_q, root_q, cur_ent, new_node;
  logic [AW-1:0]     walk_q, cur_walk, child_addr;
  logic              pend_q;
  logic [BITS_W-1:0] total_q, rem_q;
  logic              err_q;
  logic [SYM_W-1:0]  byte_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              rd_leaf, bit_val, present, idx_ok;
  logic [IDX_W-1:0]  child;
  logic              mem_we;
  logic [BITS_W-1:0] consumed;

  // Entry being written
  assign new_node.left_present  = in_data_i.left_present;
  assign new_node.left_child    = in_data_i.left_child;
  assign new_node.right_present = in_data_i.right_present;
  assign new_node.right_child   = in_data_i.right_child;
  assign new_node.symbol        = in_data_i.leaf_symbol;

  assign idx_ok = (32'(in_data_i.node_index) < NODE_COUNT);
  assign mem_we = cmd_i.accept && (in_data_i.kind == KIND_WRITE) && idx_ok;

  // Resolve the node reached by the previous bit
  assign rd_leaf  = !rdata_q.left_present && !rdata_q.right_present;
  assign cur_ent  = pend_q ? (rd_leaf ? root_q : rdata_q) : cur_q;
  assign cur_walk = (pend_q && rd_leaf) ? '0 : walk_q;

  // Child selection for the current bit
  assign bit_val    = byte_q[cmd_i.bit_sel];
  assign present    = bit_val ? cur_ent.right_present : cur_ent.left_present;
  assign child      = bit_val ? cur_ent.right_child : cur_ent.left_child;
  assign child_addr = AW'(child);

  assign consumed = total_q - rem_q;

  // Status to the controller
  assign stat_o.walk_go   = (in_data_i.kind == KIND_BYTE) && !err_q && (rem_q != '0);
  assign stat_o.nbits     = (rem_q < BITS_W'(BYTE_BITS)) ? rem_q[BIT_CNT_W-1:0]
                                                         : BIT_CNT_W'(BYTE_BITS);
  assign stat_o.need_emit = pend_q && rd_leaf;
  assign stat_o.bit_fail  = !present || !(32'(child) < NODE_COUNT);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // Node memory with registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(in_data_i.node_index)] <= new_node;
    end
    if (cmd_i.step) begin
      rdata_q <= mem[child_addr];
    end
  end

  // Walk payload: root shadow, current entry and coded byte
  always_ff @(posedge clk_i) begin
    if (mem_we && (in_data_i.node_index == '0)) begin
      root_q <= new_node;
    end
    if (cmd_i.accept && (in_data_i.kind == KIND_BYTE)) begin
      byte_q <= in_data_i.code_byte;
    end
    if (mem_we && (32'(in_data_i.node_index) == 32'(walk_q))) begin
      cur_q <= new_node;
    end else if (cmd_i.accept && (in_data_i.kind == KIND_START)) begin
      cur_q <= root_q;
    end else if (cmd_i.finish || (cmd_i.step && stat_o.bit_fail)) begin
      cur_q <= cur_ent;
    end
  end

  // Walk control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q  <= '0;
      pend_q  <= 1'b0;
      total_q <= '0;
      rem_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (cmd_i.accept && (in_data_i.kind == KIND_START)) begin
        walk_q <= '0;
        pend_q <= 1'b0;
        rem_q  <= total_q;
        err_q  <= 1'b0;
      end else if (cmd_i.accept && stat_o.walk_go) begin
        rem_q <= rem_q - BITS_W'(stat_o.nbits);
      end else if (cmd_i.step) begin
        if (stat_o.bit_fail) begin
          err_q  <= 1'b1;
          walk_q <= cur_walk;
          pend_q <= 1'b0;
        end else begin
          walk_q <= child_addr;
          pend_q <= 1'b1;
        end
      end else if (cmd_i.finish) begin
        walk_q <= cur_walk;
        pend_q <= 1'b0;
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sym || cmd_i.emit_stat) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sym) begin
      out_q.has_symbol    <= 1'b1;
      out_q.symbol        <= rdata_q.symbol;
      out_q.bits_consumed <= consumed;
      out_q.failed        <= 1'b0;
      out_q.last          <= 1'b0;
    end else if (cmd_i.emit_stat) begin
      out_q.has_symbol    <= 1'b0;
      out_q.symbol        <= '0;
      out_q.bits_consumed <= consumed;
      out_q.failed        <= err_q;
      out_q.last          <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder. Write-node items load the node table (node 0 is
// the root), a start item rewinds the walk and loads the bit count from the
// total_bits register, and each coded byte is walked least significant bit
// first. Every item yields its leaf symbols followed by one status transaction
// marked last. Item steps: a write-node, start or ignored byte is accepted and
// then yields its status; a walked byte is accepted, walks its n bits (n at
// most 8; a missing or out-of-range child ends the walk at that bit) with one
// dependent registered node memory read per bit, then yields its status.
// Output back-pressure can stall the walk and the status. The node memory has NODE_COUNT
// entries, is not cleared after reset and must be written before it is read.
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder: top level
// Joins the walk controller and the node-table datapath.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = HTWD_NODE_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [BITS_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  htwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  htwd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/htwd_checker.sv
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder: port checker
// Watches the top-level ports for result ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_defines.svh"

module htwd_checker
  import htwd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A stalled result transaction holds
  `HTWD_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o),
    "output transaction dropped or changed while stalled")

  // One item at a time: busy right after an input transaction
  `HTWD_ASSERT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o |=> !in_ready_o,
    "input accepted twice in a row")

  // A symbol result is never the closing status
  `HTWD_ASSERT_IMPLIES(a_sym_not_last, clk_i, rst_ni,
    out_valid_o && out_data_o.has_symbol, !out_data_o.last && !out_data_o.failed,
    "symbol result marked last or failed")

  // Ready comes back only with the closing status loaded
  `HTWD_ASSERT_IMPLIES(a_ready_after_status, clk_i, rst_ni,
    in_ready_o && !$past(in_ready_o) && $past(rst_ni), out_valid_o && out_data_o.last,
    "decoder idle without a status result")

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (.*);
